>>> design/tcn_pkg.sv
// shared types and constants for the timestamp carry normaliser
`default_nettype none

package tcn_pkg;

   // calendar constants
   localparam int unsigned MILLI_PER_SEC  = 1000;
   localparam int unsigned SEC_PER_MIN    = 60;
   localparam int unsigned MIN_PER_HOUR   = 60;
   localparam logic [31:0] HOUR_PER_DAY   = 32'd24;
   localparam logic [9:0]  DAYS_COMMON    = 10'd366;   // first day past a common year
   localparam logic [9:0]  DAYS_LEAP      = 10'd367;   // first day past a leap year
   localparam logic [8:0]  DAY_FIRST      = 9'd1;

   // year / 100 by reciprocal, exact for any 14-bit year
   localparam int unsigned          YEAR_W        = 14;
   localparam logic [13:0]          YEARS_CENTURY = 14'd100;
   localparam int unsigned          CENT_SHIFT    = YEAR_W + 7;
   localparam longint unsigned      CENT_RECIP_L  = ((64'd1 << CENT_SHIFT) + 64'd99) / 64'd100;
   localparam logic [14:0]          CENT_RECIP    = CENT_RECIP_L[14:0];

   // one timestamp record as it moves down the pipe
   typedef struct packed {
      logic [13:0]        year;
      logic [8:0]         day;
      logic signed [31:0] hour;
      logic signed [31:0] minute;
      logic signed [31:0] second;
      logic signed [31:0] milli;
   } tcn_rec_type;

   // per-stage control: word present, and carry chain already stopped
   typedef struct packed {
      logic valid;
      logic done;
   } tcn_ctl_type;

endpackage

`default_nettype wire

>>> design/tcn_carry_stage.sv
// one floor-divide-and-carry step: field split by a constant, quotient carried upward
`default_nettype none

module tcn_carry_stage
   import tcn_pkg::*;
#(
   parameter int unsigned DIVISOR = 60
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tcn_ctl_type        in_ctl,
   input  wire tcn_rec_type        in_rec,
   input  wire logic signed [31:0] in_num,
   input  wire logic signed [31:0] in_next,
   output      tcn_ctl_type        out_ctl,
   output      tcn_rec_type        out_rec,
   output      logic signed [31:0] out_num,
   output      logic signed [31:0] out_next
);

   // reciprocal exact for any 31-bit magnitude
   localparam int unsigned     SHIFT   = 31 + $clog2(DIVISOR);
   localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                         / 64'(DIVISOR);
   localparam logic [31:0]     RECIP   = RECIP_L[31:0];
   localparam int unsigned     REM_W   = $clog2(DIVISOR);
   localparam logic [30:0]     DIV_31  = 31'(DIVISOR);
   localparam logic [31:0]     DIV_32  = 32'(DIVISOR);
   localparam logic [REM_W-1:0] REM_MAX = REM_W'(DIVISOR - 1);

   // multiply step
   logic               neg;
   logic [30:0]        mag;

   tcn_ctl_type        ctl_a_ff;
   tcn_rec_type        rec_a_ff;
   logic signed [31:0] num_a_ff;
   logic signed [31:0] next_a_ff;
   logic               neg_a_ff;
   logic [30:0]        mag_a_ff;
   logic [62:0]        prod_a_ff;

   // negative values fold onto ~v so floor division becomes unsigned division
   assign neg = in_num[31];
   assign mag = neg ? ~in_num[30:0] : in_num[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else begin
         ctl_a_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      rec_a_ff  <= in_rec;
      num_a_ff  <= in_num;
      next_a_ff <= in_next;
      neg_a_ff  <= neg;
      mag_a_ff  <= mag;
      prod_a_ff <= 63'(mag) * 63'(RECIP);
   end

   // remainder and carry step
   logic [30:0]        quot;
   logic [30:0]        rem_full;
   logic [REM_W-1:0]   rem;
   logic signed [31:0] quot_s;
   logic               in_range;
   tcn_ctl_type        ctl_b_in;
   logic signed [31:0] num_b_in;
   logic signed [31:0] next_b_in;

   tcn_ctl_type        ctl_b_ff;
   tcn_rec_type        rec_b_ff;
   logic signed [31:0] num_b_ff;
   logic signed [31:0] next_b_ff;

   always_comb begin
      quot     = 31'(prod_a_ff >> SHIFT);
      rem_full = mag_a_ff - 31'(quot * DIV_31);
      rem      = neg_a_ff ? (REM_MAX - rem_full[REM_W-1:0]) : rem_full[REM_W-1:0];
      quot_s   = neg_a_ff ? ~{1'b0, quot} : {1'b0, quot};
      in_range = !num_a_ff[31] && (num_a_ff < DIV_32);

      ctl_b_in.valid = ctl_a_ff.valid;
      ctl_b_in.done  = ctl_a_ff.done | in_range;

      // once the chain has stopped, everything from here on passes untouched
      if (ctl_a_ff.done) begin
         num_b_in  = num_a_ff;
         next_b_in = next_a_ff;
      end else begin
         num_b_in  = {{(32-REM_W){1'b0}}, rem};
         next_b_in = next_a_ff + quot_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else begin
         ctl_b_ff <= ctl_b_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_b_ff  <= rec_a_ff;
      num_b_ff  <= num_b_in;
      next_b_ff <= next_b_in;
   end

   assign out_ctl  = ctl_b_ff;
   assign out_rec  = rec_b_ff;
   assign out_num  = num_b_ff;
   assign out_next = next_b_ff;

endmodule

`default_nettype wire

>>> design/tcn_day_stage.sv
// hour wrap, day advance with leap-year test, year rollover and result register
`default_nettype none

module tcn_day_stage
   import tcn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire tcn_ctl_type in_ctl,
   input  wire tcn_rec_type in_rec,
   output      logic        out_valid,
   output      tcn_rec_type out_rec
);

   logic [28:0]  cent_prod;
   logic [7:0]   cent;
   logic         by_century;
   logic         leap;
   logic         roll;
   logic [9:0]   day_sum;
   logic         keep_day;
   tcn_rec_type  rec_in;

   logic         valid_ff;
   tcn_rec_type  rec_ff;

   always_comb begin
      cent_prod  = 29'(in_rec.year) * 29'(CENT_RECIP);
      cent       = 8'(cent_prod >> CENT_SHIFT);
      by_century = ((14'(cent) * YEARS_CENTURY) == in_rec.year);
      leap       = by_century ? (cent[1:0] == 2'b00) : (in_rec.year[1:0] == 2'b00);

      roll     = !in_ctl.done && !in_rec.hour[31] && (in_rec.hour >= HOUR_PER_DAY);
      day_sum  = {1'b0, in_rec.day} + 10'd1;
      keep_day = (day_sum < DAYS_COMMON) || (leap && (day_sum < DAYS_LEAP));

      rec_in = in_rec;
      if (roll) begin
         rec_in.hour = in_rec.hour - HOUR_PER_DAY;
         if (keep_day) begin
            rec_in.day = day_sum[8:0];
         end else begin
            rec_in.day  = DAY_FIRST;
            rec_in.year = in_rec.year + 14'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

endmodule

`default_nettype wire

>>> design/timestamp_carry_normalizer_core.sv
// top level of the timestamp carry normaliser
`default_nettype none

// timestamp carry normaliser
//
// input channel: a word (year, day of year, hour, minute, second, millisecond)
// is taken at a rising edge where start is high and busy is low. busy is high
// only while reset is applied and for the cycle after, so once out of reset a
// new word can be given on every cycle.
//
// result channel: rsp_valid strobes for exactly one cycle with the normalised
// word on the rsp_ ports; there is no back-pressure, the receiver must take it.
//
// throughput: one word per cycle. the pipe is an input register, then two
// registers for each of the millisecond, second and minute carry steps
// (reciprocal multiply, then remainder and carry), then the hour/day/year step
// into the result register. the multiply in each carry step sets the stage
// split.
//
// reset clears all valid flags, so any words in flight are dropped; no state
// survives between words, each result depends only on its own word.
module timestamp_carry_normalizer_core
   import tcn_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [13:0]        req_year_in,
   input  wire logic [8:0]         req_day_in,
   input  wire logic signed [31:0] req_hour_in,
   input  wire logic signed [31:0] req_minute_in,
   input  wire logic signed [31:0] req_second_in,
   input  wire logic signed [31:0] req_milli_in,
   output      logic               rsp_valid,
   output      logic [13:0]        rsp_year_out,
   output      logic [8:0]         rsp_day_out,
   output      logic signed [31:0] rsp_hour_out,
   output      logic signed [31:0] rsp_minute_out,
   output      logic signed [31:0] rsp_second_out,
   output      logic [9:0]         rsp_milli_out
);

   // busy only around reset
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // input register
   tcn_ctl_type ctl_in;
   tcn_ctl_type ctl0_ff;
   tcn_rec_type rec0_ff;

   always_comb begin
      ctl_in.valid = start & ~busy_ff;
      ctl_in.done  = 1'b0;      // nothing has stopped the carry chain yet
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else begin
         ctl0_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      rec0_ff.year   <= req_year_in;
      rec0_ff.day    <= req_day_in;
      rec0_ff.hour   <= req_hour_in;
      rec0_ff.minute <= req_minute_in;
      rec0_ff.second <= req_second_in;
      rec0_ff.milli  <= req_milli_in;
   end

   // millisecond step: milli mod 1000, quotient into seconds
   tcn_ctl_type        ms_ctl;
   tcn_rec_type        ms_rec;
   logic signed [31:0] ms_num;
   logic signed [31:0] ms_next;
   tcn_rec_type        rec1;

   tcn_carry_stage #(
      .DIVISOR (MILLI_PER_SEC)
   ) u_milli_stage (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ctl0_ff),
      .in_rec   (rec0_ff),
      .in_num   (rec0_ff.milli),
      .in_next  (rec0_ff.second),
      .out_ctl  (ms_ctl),
      .out_rec  (ms_rec),
      .out_num  (ms_num),
      .out_next (ms_next)
   );

   always_comb begin
      rec1        = ms_rec;
      rec1.milli  = ms_num;
      rec1.second = ms_next;
   end

   // second step: second mod 60, quotient into minutes
   tcn_ctl_type        sc_ctl;
   tcn_rec_type        sc_rec;
   logic signed [31:0] sc_num;
   logic signed [31:0] sc_next;
   tcn_rec_type        rec2;

   tcn_carry_stage #(
      .DIVISOR (SEC_PER_MIN)
   ) u_second_stage (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ms_ctl),
      .in_rec   (rec1),
      .in_num   (rec1.second),
      .in_next  (rec1.minute),
      .out_ctl  (sc_ctl),
      .out_rec  (sc_rec),
      .out_num  (sc_num),
      .out_next (sc_next)
   );

   always_comb begin
      rec2        = sc_rec;
      rec2.second = sc_num;
      rec2.minute = sc_next;
   end

   // minute step: minute mod 60, quotient into hours
   tcn_ctl_type        mn_ctl;
   tcn_rec_type        mn_rec;
   logic signed [31:0] mn_num;
   logic signed [31:0] mn_next;
   tcn_rec_type        rec3;

   tcn_carry_stage #(
      .DIVISOR (MIN_PER_HOUR)
   ) u_minute_stage (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (sc_ctl),
      .in_rec   (rec2),
      .in_num   (rec2.minute),
      .in_next  (rec2.hour),
      .out_ctl  (mn_ctl),
      .out_rec  (mn_rec),
      .out_num  (mn_num),
      .out_next (mn_next)
   );

   always_comb begin
      rec3        = mn_rec;
      rec3.minute = mn_num;
      rec3.hour   = mn_next;
   end

   // hour wrap and day / year rollover, into the result register
   tcn_rec_type rsp_rec;

   tcn_day_stage u_day_stage (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (mn_ctl),
      .in_rec    (rec3),
      .out_valid (rsp_valid),
      .out_rec   (rsp_rec)
   );

   assign rsp_year_out   = rsp_rec.year;
   assign rsp_day_out    = rsp_rec.day;
   assign rsp_hour_out   = rsp_rec.hour;
   assign rsp_minute_out = rsp_rec.minute;
   assign rsp_second_out = rsp_rec.second;
   // always 0 to 999 by here, so the low ten bits carry it all
   assign rsp_milli_out  = rsp_rec.milli[9:0];

endmodule

`default_nettype wire

>>> verif/tcn_carry_checker.sv
// checker that predicts and compares every normalised timestamp word
`timescale 1ns / 1ps

module tcn_carry_checker
   import tcn_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [13:0]        req_year_in,
   input  wire logic [8:0]         req_day_in,
   input  wire logic signed [31:0] req_hour_in,
   input  wire logic signed [31:0] req_minute_in,
   input  wire logic signed [31:0] req_second_in,
   input  wire logic signed [31:0] req_milli_in,
   input  wire logic               rsp_valid,
   input  wire logic [13:0]        rsp_year_out,
   input  wire logic [8:0]         rsp_day_out,
   input  wire logic signed [31:0] rsp_hour_out,
   input  wire logic signed [31:0] rsp_minute_out,
   input  wire logic signed [31:0] rsp_second_out,
   input  wire logic [9:0]         rsp_milli_out,
   output int                      fail_count,
   output int                      pending_words,
   output int                      checked_words
);

   // signed 64-bit copies of the divisors, kept apart from the unsigned package values
   localparam longint     MS_DIV     = 1000;
   localparam longint     SEC_DIV    = 60;
   localparam longint     MIN_DIV    = 60;
   localparam longint     HOUR_DAY   = 24;
   localparam logic [9:0] END_COMMON = 10'd366;
   localparam logic [9:0] END_LEAP   = 10'd367;

   tcn_rec_type expected_words[$];

   initial begin
      fail_count    = 0;
      pending_words = 0;
      checked_words = 0;
   end

   function automatic longint floor_quot(longint v, longint d);
      longint q;
      q = v / d;
      if ((v % d) != 0 && v < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint wrap32(longint v);
      logic signed [31:0] t;
      t = v[31:0];
      return longint'(t);
   endfunction

   function automatic bit leap_year(logic [13:0] y);
      int yr;
      yr = int'(y);
      return (yr % 400 == 0) || (yr % 100 != 0 && yr % 4 == 0);
   endfunction

   // carry chain, stopping at the first field that is already in range
   function automatic tcn_rec_type normalise_word(tcn_rec_type w);
      tcn_rec_type r;
      longint ms, sec, mn, hr, q;
      logic [9:0] dy;
      r   = w;
      ms  = longint'(w.milli);
      sec = longint'(w.second);
      mn  = longint'(w.minute);
      hr  = longint'(w.hour);
      if (ms >= 0 && ms < MS_DIV) return r;
      q   = floor_quot(ms, MS_DIV);
      ms  = ms - q * MS_DIV;
      sec = wrap32(sec + q);
      r.milli  = ms[31:0];
      r.second = sec[31:0];
      if (sec >= 0 && sec < SEC_DIV) return r;
      q   = floor_quot(sec, SEC_DIV);
      sec = sec - q * SEC_DIV;
      mn  = wrap32(mn + q);
      r.second = sec[31:0];
      r.minute = mn[31:0];
      if (mn >= 0 && mn < MIN_DIV) return r;
      q   = floor_quot(mn, MIN_DIV);
      mn  = mn - q * MIN_DIV;
      hr  = wrap32(hr + q);
      r.minute = mn[31:0];
      r.hour   = hr[31:0];
      if (hr < HOUR_DAY) return r;
      hr = hr - HOUR_DAY;
      r.hour = hr[31:0];
      dy = {1'b0, w.day} + 10'd1;
      if (dy < END_COMMON || (leap_year(w.year) && dy < END_LEAP)) begin
         r.day = dy[8:0];
         return r;
      end
      r.day  = 9'd1;
      r.year = w.year + 14'd1;
      return r;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      tcn_rec_type in_word, exp_word;
      if (!reset) begin
         if (start && !busy) begin
            in_word = '{req_year_in, req_day_in, req_hour_in, req_minute_in,
                        req_second_in, req_milli_in};
            expected_words.push_back(normalise_word(in_word));
         end
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $display("%0t ns: result word with nothing expected, year %0d day %0d",
                        $time, rsp_year_out, rsp_day_out);
               fail_count++;
            end else begin
               exp_word = expected_words.pop_front();
               check_field("year",   longint'(exp_word.year),   longint'(rsp_year_out));
               check_field("day",    longint'(exp_word.day),    longint'(rsp_day_out));
               check_field("hour",   longint'(exp_word.hour),   longint'(rsp_hour_out));
               check_field("minute", longint'(exp_word.minute), longint'(rsp_minute_out));
               check_field("second", longint'(exp_word.second), longint'(rsp_second_out));
               check_field("milli",  longint'(exp_word.milli[9:0]),
                           longint'(rsp_milli_out));
               checked_words++;
            end
         end
      end
      pending_words = expected_words.size();
   end

endmodule

>>> verif/timestamp_carry_normalizer_core_test.sv
// top of the timestamp carry normaliser testbench: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module timestamp_carry_normalizer_core_test;
   import tcn_pkg::*;

   localparam int RANDOM_WORDS = 1950;
   localparam int STALL_LIMIT  = 500;   // cycles with no word moving on either side
   localparam int DRAIN_CYCLES = 12;    // allowance for anything still in the pipe after the last result
   localparam int MOST_POS     = 32'sh7fff_ffff;
   localparam int MOST_NEG     = 32'sh8000_0000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [13:0]        req_year_in   = '0;
   logic [8:0]         req_day_in    = 9'd1;
   logic signed [31:0] req_hour_in   = '0;
   logic signed [31:0] req_minute_in = '0;
   logic signed [31:0] req_second_in = '0;
   logic signed [31:0] req_milli_in  = '0;
   logic               rsp_valid;
   logic [13:0]        rsp_year_out;
   logic [8:0]         rsp_day_out;
   logic signed [31:0] rsp_hour_out;
   logic signed [31:0] rsp_minute_out;
   logic signed [31:0] rsp_second_out;
   logic [9:0]         rsp_milli_out;

   int fail_count;
   int pending_words;
   int checked_words;
   int sent_words = 0;
   int stall_cycles = 0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   timestamp_carry_normalizer_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_year_in    (req_year_in),
      .req_day_in     (req_day_in),
      .req_hour_in    (req_hour_in),
      .req_minute_in  (req_minute_in),
      .req_second_in  (req_second_in),
      .req_milli_in   (req_milli_in),
      .rsp_valid      (rsp_valid),
      .rsp_year_out   (rsp_year_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_second_out (rsp_second_out),
      .rsp_milli_out  (rsp_milli_out)
   );

   // the checker sits beside the block and watches both channels
   tcn_carry_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_year_in    (req_year_in),
      .req_day_in     (req_day_in),
      .req_hour_in    (req_hour_in),
      .req_minute_in  (req_minute_in),
      .req_second_in  (req_second_in),
      .req_milli_in   (req_milli_in),
      .rsp_valid      (rsp_valid),
      .rsp_year_out   (rsp_year_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_second_out (rsp_second_out),
      .rsp_milli_out  (rsp_milli_out),
      .fail_count     (fail_count),
      .pending_words  (pending_words),
      .checked_words  (checked_words)
   );

   // watchdog: nothing accepted on either side for too long means a hang
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: watchdog expired, %0d words still expected", $time, pending_words);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic tcn_rec_type make_word(int y, int d, int h, int m, int s, int ms);
      tcn_rec_type w;
      w.year   = y[13:0];
      w.day    = d[8:0];
      w.hour   = h;
      w.minute = m;
      w.second = s;
      w.milli  = ms;
      return w;
   endfunction

   // a value for a field whose range is [0, limit)
   function automatic int pick_field(int limit);
      int unsigned mode;
      mode = $urandom_range(0, 9);
      if (mode < 5) return int'($urandom_range(0, 6 * limit)) - 3 * limit;
      if (mode < 9) begin
         case ($urandom_range(0, 6))
            0:       return -1;
            1:       return 0;
            2:       return limit - 1;
            3:       return limit;
            4:       return -limit;
            5:       return MOST_POS;
            default: return MOST_NEG;
         endcase
      end
      return $urandom;
   endfunction

   function automatic tcn_rec_type random_word();
      tcn_rec_type w;
      int unsigned shape;
      shape = $urandom_range(0, 99);
      // century and leap years matter most when the day rolls over
      if ($urandom_range(0, 9) < 7) begin
         w.year = 14'($urandom_range(0, 9999));
      end else begin
         case ($urandom_range(0, 7))
            0:       w.year = 14'd0;
            1:       w.year = 14'd1900;
            2:       w.year = 14'd2000;
            3:       w.year = 14'd2100;
            4:       w.year = 14'd2400;
            5:       w.year = 14'd2023;
            6:       w.year = 14'd2024;
            default: w.year = 14'd9999;
         endcase
      end
      w.day = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(1, 367))
                                          : 9'($urandom_range(360, 367));
      if (shape < 55) begin
         // carry chain that usually runs all the way up to the day
         w.milli  = int'($urandom_range(0, 3999)) - 2000;
         w.second = $urandom_range(56, 62);
         w.minute = $urandom_range(56, 62);
         w.hour   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 50)) - 25
                                                 : int'($urandom_range(21, 26));
      end else if (shape < 85) begin
         w.milli  = pick_field(1000);
         w.second = pick_field(60);
         w.minute = pick_field(60);
         w.hour   = pick_field(24);
      end else begin
         w.milli  = $urandom;
         w.second = $urandom;
         w.minute = $urandom;
         w.hour   = $urandom;
      end
      return w;
   endfunction

   // present one word and hold it until the block takes it
   task automatic drive_word(tcn_rec_type w);
      @(negedge clock);
      start         = 1'b1;
      req_year_in   = w.year;
      req_day_in    = w.day;
      req_hour_in   = w.hour;
      req_minute_in = w.minute;
      req_second_in = w.second;
      req_milli_in  = w.milli;
      do @(posedge clock); while (busy);
      sent_words++;
   endtask

   // sender gap, with junk on the data ports while start is low
   task automatic pause_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start         = 1'b0;
         req_year_in   = 14'($urandom);
         req_day_in    = 9'($urandom);
         req_hour_in   = $urandom;
         req_minute_in = $urandom;
         req_second_in = $urandom;
         req_milli_in  = $urandom;
      end
   endtask

   initial begin : stimulus
      tcn_rec_type directed_words[$];
      int burst_len;
      int done_words;

      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed words
      directed_words.push_back(make_word(0, 1, 0, 0, 0, 0));               // nothing to carry
      directed_words.push_back(make_word(9999, 367, 23, 59, 59, 999));     // top of range, no carry
      directed_words.push_back(make_word(2023, 100, 5, 10, 20, 1000));     // one second carry only
      directed_words.push_back(make_word(2023, 100, 5, 10, 59, 1000));     // into the minute
      directed_words.push_back(make_word(2023, 100, 0, 0, 0, -1));         // borrow all the way, hour -1
      directed_words.push_back(make_word(2023, 100, 3, 7, 9, MOST_POS));
      directed_words.push_back(make_word(2023, 100, 3, 7, 9, MOST_NEG));
      directed_words.push_back(make_word(2023, 1, 23, 59, 59, 1000));      // day advance
      directed_words.push_back(make_word(2023, 365, 23, 59, 59, 1000));    // common year rollover
      directed_words.push_back(make_word(2024, 365, 23, 59, 59, 1000));    // leap year keeps day 366
      directed_words.push_back(make_word(2024, 366, 23, 59, 59, 1000));    // leap year rollover
      directed_words.push_back(make_word(1900, 365, 23, 59, 59, 1000));    // century, not leap
      directed_words.push_back(make_word(2000, 365, 23, 59, 59, 1000));    // four-century, leap
      directed_words.push_back(make_word(9999, 365, 23, 59, 59, 1000));    // year runs past 9999
      directed_words.push_back(make_word(2024, 367, 23, 59, 59, 1000));    // day already past the end
      directed_words.push_back(make_word(2023, 50, 100, 59, 59, 1000));    // big hour loses 24 once
      directed_words.push_back(make_word(2023, 50, MOST_POS, 59, 59, 1000)); // hour wraps negative
      directed_words.push_back(make_word(2023, 50, 7, 8, MOST_POS, 1000)); // second wraps on carry
      directed_words.push_back(make_word(2023, 50, 7, MOST_NEG, 59, 1000)); // minute far below range
      directed_words.push_back(make_word(2023, 50, -40, 1000, 5000, 500)); // early stop, rest untouched
      directed_words.push_back(make_word(2023, 50, -40, 1000, 30, 5000));  // stop at the second
      directed_words.push_back(make_word(2023, 50, -5, 59, 59, 1000));     // negative hour at its stage
      directed_words.push_back(make_word(2023, 50, 10, MOST_POS, MOST_POS, MOST_POS));
      directed_words.push_back(make_word(2023, 50, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
      foreach (directed_words[i]) drive_word(directed_words[i]);

      // hold the sender off until every directed result is back
      pause_sender(1);
      while (pending_words != 0) @(negedge clock);

      // random bursts, sometimes back to back with no gap
      done_words = 0;
      while (done_words < RANDOM_WORDS) begin
         burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
         repeat (burst_len) begin
            drive_word(random_word());
            done_words++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end

      // drain, then allow for anything stray still in the pipe
      pause_sender(1);
      while (pending_words != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d timestamp words (directed carry, leap and wrap cases plus random bursts)",
               sent_words);
      $display("checked %0d normalised results, %0d field mismatches", checked_words, fail_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
